>>> design/flit_result_reassembler_macros.svh
// Assertion helpers for the flit result reassembler.
// Both forms check on the rising clock edge and stay quiet while reset is high.
`ifndef FLIT_RESULT_REASSEMBLER_MACROS_SVH
`define FLIT_RESULT_REASSEMBLER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define FRR_ASSERT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");
// Next-cycle implication.
`define FRR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");
`else
`define FRR_ASSERT(label, clk, rst, ante, cons)
`define FRR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> design/frr_pkg.sv
`default_nettype none

package frr_pkg;

  // Output store geometry
  localparam int unsigned OUT_LEN = 1000;
  localparam int unsigned OUT_AW  = $clog2(OUT_LEN);

  // Payload store geometry
  localparam int unsigned PAY_DEPTH = 256;
  localparam int unsigned PAY_AW    = $clog2(PAY_DEPTH);
  localparam int unsigned WCNT_W    = PAY_AW + 1;

  // Beat field widths
  localparam int unsigned FLIT_W  = 34;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned RIDX_W  = 10;
  localparam int unsigned CHUNK_W = 8;

  // Configuration port
  localparam int unsigned CFG_IW = 3;
  localparam int unsigned CFG_DW = 8;

  typedef enum logic [CFG_IW-1:0] {
    CFG_EXPECTED = 3'd0,
    CFG_HEAD     = 3'd1,
    CFG_BODY     = 3'd2,
    CFG_TAIL     = 3'd3,
    CFG_RTYPE    = 3'd4
  } cfg_reg_t;

  // Input beat function codes
  localparam logic FUNC_FLIT = 1'b0;
  localparam logic FUNC_READ = 1'b1;

endpackage

`default_nettype wire

>>> design/frr_item_if.sv
`default_nettype none

interface frr_item_if;
  import frr_pkg::*;

  logic              valid;
  logic              ready;
  logic              func;
  logic [FLIT_W-1:0] flit;
  logic [RIDX_W-1:0] read_index;

  modport source (output valid, output func, output flit, output read_index, input ready);
  modport sink   (input valid, input func, input flit, input read_index, output ready);
endinterface

`default_nettype wire

>>> design/frr_result_if.sv
`default_nettype none

interface frr_result_if;
  import frr_pkg::*;

  logic               valid;
  logic               ready;
  logic [WORD_W-1:0]  read_value;
  logic               chunk_merged;
  logic               all_done;
  logic [CHUNK_W-1:0] chunks_received;

  modport source (output valid, output read_value, output chunk_merged, output all_done,
                  output chunks_received, input ready);
  modport sink   (input valid, input read_value, input chunk_merged, input all_done,
                  input chunks_received, output ready);
endinterface

`default_nettype wire

>>> design/frr_cfg_if.sv
`default_nettype none

interface frr_cfg_if;
  import frr_pkg::*;

  logic              valid;
  logic              ready;
  logic [CFG_IW-1:0] index;
  logic [CFG_DW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> design/frr_ram.sv
`default_nettype none

module frr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> design/frr_f2i.sv
`default_nettype none

module frr_f2i (
  input  logic [frr_pkg::WORD_W-1:0] fbits,
  output logic signed [31:0]         ival
);
  import frr_pkg::*;

  logic [7:0]  ex;
  logic [4:0]  sh_amt;
  logic [53:0] shifted;
  logic [30:0] mag;
  logic        neg;

  assign ex  = fbits[30:23];
  assign neg = fbits[31];

  // Align mantissa: value = {1,frac} * 2^(ex-127) / 2^23, truncated
  always_comb begin
    sh_amt  = 5'(ex - 8'd127);
    shifted = {30'd0, 1'b1, fbits[22:0]} << sh_amt;
    mag     = shifted[53:23];
  end

  // Handle NaN, infinity, saturation and sub-unity magnitudes
  always_comb begin
    if (ex == 8'hFF) begin
      if (fbits[22:0] != 23'd0) begin
        ival = 32'sd0;
      end else begin
        ival = neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end
    end else if (ex < 8'd127) begin
      ival = 32'sd0;
    end else if (ex >= 8'd158) begin
      ival = neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      ival = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  end

endmodule

`default_nettype wire

>>> design/flit_result_reassembler.sv
// Channel  Role    Beat contents
// -------  ------  ---------------------------------------------------------
// item     sink    func, flit[33:0], read_index[9:0]
// result   source  read_value[31:0], chunk_merged, all_done, chunks_received[7:0]
// cfg      sink    index[2:0], data[7:0]; always ready
//
// Body, head or ignored flit: decode, then result; output read: decode, output store read, result.
// Tail that merges: reads start and count, then copies N words (up to 254); one payload
// store read port feeds the copy, one word per read/write pair.
// Reset starts a clearing pass over all 1000 words of the output store; no item is taken
// during it, configuration writes are.
// A finished result waits in the output register; the next item is accepted
// meanwhile and stalls before its own result until that register is free.
`default_nettype none
`include "flit_result_reassembler_macros.svh"

module flit_result_reassembler (
  input  logic       clk,
  input  logic       rst,
  frr_item_if.sink   item,
  frr_result_if.source result,
  frr_cfg_if.sink    cfg
);
  import frr_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_RD_OUT,
    S_RD_PAY0,
    S_CONV0,
    S_CONV1,
    S_LIMIT,
    S_CP_RD,
    S_CP_WR,
    S_RESP
  } state_t;

  state_t state;

  // Configuration registers
  logic [CHUNK_W-1:0] exp_chunks;
  logic [1:0]         head_code;
  logic [1:0]         body_code;
  logic [1:0]         tail_code;
  logic [3:0]         result_type;

  // Held beat
  logic              func_q;
  logic [FLIT_W-1:0] flit_q;
  logic [RIDX_W-1:0] rd_index_q;

  // Packet and merge state
  logic               assembling;
  logic [3:0]         held_type;
  logic [WCNT_W-1:0]  word_count;
  logic [CHUNK_W-1:0] chunk_count;
  logic               done_flag;
  logic signed [31:0] start_val;
  logic signed [31:0] count_val;
  logic [PAY_AW-1:0]  copy_len;
  logic [PAY_AW-1:0]  copy_i;
  logic [OUT_AW-1:0]  clr_addr;
  logic [WORD_W-1:0]  res_value;
  logic               res_merged;

  // Memory ports
  logic              pay_we;
  logic [PAY_AW-1:0] pay_waddr;
  logic [PAY_AW-1:0] pay_raddr;
  logic [WORD_W-1:0] pay_rdata;
  logic              oram_we;
  logic [OUT_AW-1:0] oram_waddr;
  logic [WORD_W-1:0] oram_wdata;
  logic [WORD_W-1:0] oram_rdata;

  // Decode and datapath helpers
  logic [1:0]         kind;
  logic               is_head;
  logic               is_body;
  logic               is_tail;
  logic               merge_go;
  logic               rd_ok;
  logic signed [31:0] conv_out;
  logic signed [32:0] tgt;
  logic               tgt_ok;
  logic [PAY_AW-1:0]  avail;
  logic [CHUNK_W-1:0] chunk_next;

  assign kind    = flit_q[33:32];
  assign is_head = (kind == head_code);
  assign is_body = !is_head && (kind == body_code);
  assign is_tail = !is_head && !is_body && (kind == tail_code);
  assign merge_go = is_tail && assembling && (held_type == result_type) &&
                    (word_count >= WCNT_W'(2));
  assign rd_ok   = (rd_index_q < RIDX_W'(OUT_LEN));
  assign avail   = PAY_AW'(word_count - WCNT_W'(2));
  assign tgt     = $signed({start_val[31], start_val}) + $signed({25'd0, copy_i});
  assign tgt_ok  = !tgt[32] && (tgt < $signed(33'(OUT_LEN)));
  assign chunk_next = (chunk_count != {CHUNK_W{1'b1}}) ? chunk_count + CHUNK_W'(1) : chunk_count;

  assign item.ready = (state == S_IDLE);
  assign cfg.ready  = 1'b1;

  // Payload store: body words in, merge reads out
  always_comb begin
    pay_we    = (state == S_DECODE) && (func_q == FUNC_FLIT) && is_body && assembling &&
                !word_count[WCNT_W-1];
    pay_waddr = word_count[PAY_AW-1:0];
    case (state)
      S_RD_PAY0: pay_raddr = PAY_AW'(0);
      S_CONV0:   pay_raddr = PAY_AW'(1);
      default:   pay_raddr = copy_i + PAY_AW'(2);
    endcase
  end

  frr_ram #(.WIDTH(WORD_W), .DEPTH(PAY_DEPTH)) u_pay_ram (
    .clk   (clk),
    .we    (pay_we),
    .waddr (pay_waddr),
    .wdata (flit_q[31:0]),
    .raddr (pay_raddr),
    .rdata (pay_rdata)
  );

  // Output store: clearing pass or merge copy
  always_comb begin
    if (state == S_CLEAR) begin
      oram_we    = 1'b1;
      oram_waddr = clr_addr;
      oram_wdata = '0;
    end else begin
      oram_we    = (state == S_CP_WR) && tgt_ok;
      oram_waddr = tgt[OUT_AW-1:0];
      oram_wdata = pay_rdata;
    end
  end

  frr_ram #(.WIDTH(WORD_W), .DEPTH(OUT_LEN)) u_out_ram (
    .clk   (clk),
    .we    (oram_we),
    .waddr (oram_waddr),
    .wdata (oram_wdata),
    .raddr (rd_index_q[OUT_AW-1:0]),
    .rdata (oram_rdata)
  );

  // Shared float-to-integer unit, fed from the payload read port
  frr_f2i u_f2i (
    .fbits (pay_rdata),
    .ival  (conv_out)
  );

  // Sequencer, state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      exp_chunks   <= CHUNK_W'(1);
      head_code    <= 2'd0;
      body_code    <= 2'd1;
      tail_code    <= 2'd2;
      result_type  <= 4'd3;
      assembling   <= 1'b0;
      held_type    <= 4'hF;
      word_count   <= '0;
      chunk_count  <= '0;
      done_flag    <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      // Configuration writes
      if (cfg.valid) begin
        case (cfg.index)
          CFG_EXPECTED: exp_chunks  <= cfg.data;
          CFG_HEAD:     head_code   <= cfg.data[1:0];
          CFG_BODY:     body_code   <= cfg.data[1:0];
          CFG_TAIL:     tail_code   <= cfg.data[1:0];
          CFG_RTYPE:    result_type <= cfg.data[3:0];
          default: ;
        endcase
      end

      // Drop the result beat once taken; a waiting result reloads it in place
      if (result.valid && result.ready && state != S_RESP) begin
        result.valid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + OUT_AW'(1);
          if (clr_addr == OUT_AW'(OUT_LEN - 1)) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (item.valid) begin
            func_q     <= item.func;
            flit_q     <= item.flit;
            rd_index_q <= item.read_index;
            state      <= S_DECODE;
          end
        end

        S_DECODE: begin
          res_value  <= '0;
          res_merged <= 1'b0;
          if (func_q == FUNC_READ) begin
            state <= S_RD_OUT;
          end else if (merge_go) begin
            state <= S_RD_PAY0;
          end else begin
            state <= S_RESP;
            if (is_head) begin
              assembling <= 1'b1;
              held_type  <= flit_q[27:24];
              word_count <= '0;
            end else if (is_body) begin
              if (assembling && !word_count[WCNT_W-1]) begin
                word_count <= word_count + WCNT_W'(1);
              end
            end else if (is_tail && assembling) begin
              assembling <= 1'b0;
              held_type  <= 4'hF;
              word_count <= '0;
            end
          end
        end

        S_RD_OUT: begin
          res_value <= rd_ok ? oram_rdata : '0;
          state     <= S_RESP;
        end

        S_RD_PAY0: begin
          state <= S_CONV0;
        end

        // Word 0 gives the start index
        S_CONV0: begin
          start_val <= conv_out;
          state     <= S_CONV1;
        end

        // Word 1 gives the count
        S_CONV1: begin
          count_val <= conv_out;
          state     <= S_LIMIT;
        end

        // Clip the count to the stored words
        S_LIMIT: begin
          copy_i <= '0;
          if (count_val <= 32'sd0) begin
            copy_len <= '0;
          end else if (count_val < $signed({24'd0, avail})) begin
            copy_len <= count_val[PAY_AW-1:0];
          end else begin
            copy_len <= avail;
          end
          state <= S_CP_RD;
        end

        S_CP_RD: begin
          if (copy_i == copy_len) begin
            chunk_count <= chunk_next;
            if (chunk_next >= exp_chunks) begin
              done_flag <= 1'b1;
            end
            assembling <= 1'b0;
            held_type  <= 4'hF;
            word_count <= '0;
            res_merged <= 1'b1;
            state      <= S_RESP;
          end else begin
            state <= S_CP_WR;
          end
        end

        S_CP_WR: begin
          copy_i <= copy_i + PAY_AW'(1);
          state  <= S_CP_RD;
        end

        // Hand the result to the output register when it is free
        S_RESP: begin
          if (!result.valid || result.ready) begin
            result.valid           <= 1'b1;
            result.read_value      <= res_value;
            result.chunk_merged    <= res_merged;
            result.all_done        <= done_flag;
            result.chunks_received <= chunk_count;
            state                  <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  `FRR_ASSERT(a_no_take_in_clear, clk, rst, state == S_CLEAR, !item.ready)
  `FRR_ASSERT(a_copy_in_range, clk, rst, oram_we && state == S_CP_WR, oram_waddr < OUT_AW'(OUT_LEN))
  `FRR_ASSERT(a_copy_bound, clk, rst, state == S_CP_RD, copy_i <= copy_len)
  `FRR_ASSERT(a_merge_counted, clk, rst, result.valid && result.chunk_merged, result.chunks_received != '0)
  `FRR_ASSERT_NEXT(a_done_sticky, clk, rst, done_flag, done_flag)

endmodule

`default_nettype wire
